[sv/iib_pkg.sv]
package iib_pkg;

	localparam int unsigned DEPTH_DEF = 1024;
	localparam int unsigned IDX_W     = 10;
	localparam int unsigned ENTRY_W   = 64;

	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_SORT  = 2'd1,
		KIND_FETCH = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_PHASE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD0,
		S_CARRY,
		S_SCAN,
		S_WB,
		S_PRIME0,
		S_PRIME1
	} state_t;

	typedef struct packed {
		logic go;
		logic sort_start;
		logic rd0;
		logic load_carry;
		logic scan;
		logic pass_end;
		logic prime0;
		logic prime1;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic pass_last;
		logic sort_trivial;
	} stat_t;

endpackage

[sv/iib_ctrl.sv]
module iib_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [1:0]      kind,
	input  iib_pkg::stat_t  stat,
	output iib_pkg::cmd_t   cmd,
	output logic            busy
);

	iib_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iib_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = (state_q != iib_pkg::S_IDLE);
		case (state_q)
			iib_pkg::S_IDLE: begin
				cmd.go = start;
				if (start && kind == iib_pkg::KIND_SORT) begin
					cmd.sort_start = 1'b1;
					state_d = stat.sort_trivial ? iib_pkg::S_PRIME0 : iib_pkg::S_RD0;
				end
			end
			iib_pkg::S_RD0: begin
				cmd.rd0 = 1'b1;
				state_d = iib_pkg::S_CARRY;
			end
			iib_pkg::S_CARRY: begin
				cmd.load_carry = 1'b1;
				state_d = iib_pkg::S_SCAN;
			end
			iib_pkg::S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_done) begin
					state_d = iib_pkg::S_WB;
				end
			end
			iib_pkg::S_WB: begin
				cmd.pass_end = 1'b1;
				state_d = stat.pass_last ? iib_pkg::S_PRIME0 : iib_pkg::S_RD0;
			end
			iib_pkg::S_PRIME0: begin
				cmd.prime0 = 1'b1;
				state_d = iib_pkg::S_PRIME1;
			end
			iib_pkg::S_PRIME1: begin
				cmd.prime1 = 1'b1;
				state_d = iib_pkg::S_IDLE;
			end
			default: begin
				state_d = iib_pkg::S_IDLE;
			end
		endcase
	end

endmodule

[sv/iib_dp.sv]
module iib_dp #(
	parameter int unsigned DEPTH = iib_pkg::DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  iib_pkg::cmd_t             cmd,
	output iib_pkg::stat_t            stat,
	input  logic [1:0]                kind,
	input  logic [23:0]               word_id,
	input  logic [23:0]               doc_id,
	input  logic [15:0]               pos,
	output logic                      done,
	output logic [1:0]                status,
	output logic [23:0]               out_word,
	output logic [23:0]               out_doc,
	output logic [15:0]               out_pos,
	output logic [iib_pkg::IDX_W-1:0] hit_index,
	output logic [iib_pkg::IDX_W-1:0] posting_index,
	output logic [iib_pkg::IDX_W-1:0] word_index,
	output logic                      posting_start,
	output logic                      posting_end,
	output logic                      word_start,
	output logic                      word_end,
	output logic                      last
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned EW = iib_pkg::ENTRY_W;
	localparam int unsigned IW = iib_pkg::IDX_W;

	logic [EW-1:0] mem_q [DEPTH];
	logic [EW-1:0] rdata_q, carry_q, cur_q, prev_q;
	logic [CW-1:0] count_q, rp_q, m_q;
	logic [AW-1:0] j_q;
	logic          sorted_q;
	logic [IW-1:0] pc_q, wc_q;

	logic          is_load, is_sort, is_fetch, is_clear;
	logic          load_ok, fetch_ok;
	logic [AW-1:0] raddr, waddr;
	logic [EW-1:0] wdata, lo_val, hi_val;
	logic          we;
	logic          p_st, w_st, p_en, w_en, is_last;
	logic [IW-1:0] pc_n, wc_n;
	logic [1:0]    st_n;

	assign is_load  = cmd.go && kind == iib_pkg::KIND_LOAD;
	assign is_sort  = cmd.sort_start;
	assign is_fetch = cmd.go && kind == iib_pkg::KIND_FETCH;
	assign is_clear = cmd.go && kind == iib_pkg::KIND_CLEAR;
	assign load_ok  = is_load && !sorted_q && count_q < CW'(DEPTH);
	assign fetch_ok = is_fetch && sorted_q && rp_q < count_q;

	// bubble step: smaller stays behind, larger carried forward
	assign lo_val = (rdata_q < carry_q) ? rdata_q : carry_q;
	assign hi_val = (rdata_q < carry_q) ? carry_q : rdata_q;

	assign stat.scan_done    = (CW'(j_q) == m_q - CW'(1));
	assign stat.pass_last    = (m_q < CW'(3));
	assign stat.sort_trivial = (count_q < CW'(2));

	always_comb begin
		raddr = AW'(rp_q + CW'(1));
		if (fetch_ok) begin
			raddr = AW'(rp_q + CW'(2));
		end else if (cmd.rd0 || cmd.prime0) begin
			raddr = '0;
		end else if (cmd.load_carry || cmd.prime1) begin
			raddr = AW'(1);
		end else if (cmd.scan) begin
			raddr = AW'(j_q + AW'(1));
		end
		we    = 1'b0;
		waddr = count_q[AW-1:0];
		wdata = {word_id, doc_id, pos};
		if (load_ok) begin
			we = 1'b1;
		end else if (cmd.scan) begin
			we    = 1'b1;
			waddr = j_q - AW'(1);
			wdata = lo_val;
		end else if (cmd.pass_end) begin
			we    = 1'b1;
			waddr = AW'(m_q - CW'(1));
			wdata = carry_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	// fetch window: prev_q, cur_q and rdata_q as the next entry
	always_comb begin
		p_st    = (rp_q == '0) || (prev_q[EW-1:16] != cur_q[EW-1:16]);
		w_st    = (rp_q == '0) || (prev_q[EW-1:40] != cur_q[EW-1:40]);
		is_last = (rp_q + CW'(1) >= count_q);
		p_en    = is_last || (rdata_q[EW-1:16] != cur_q[EW-1:16]);
		w_en    = is_last || (rdata_q[EW-1:40] != cur_q[EW-1:40]);
		pc_n    = pc_q + IW'(p_st && rp_q != '0);
		wc_n    = wc_q + IW'(w_st && rp_q != '0);
		st_n    = iib_pkg::ST_OK;
		if (is_load && sorted_q) begin
			st_n = iib_pkg::ST_PHASE;
		end else if (is_load && !load_ok) begin
			st_n = iib_pkg::ST_FULL;
		end else if (is_fetch && !sorted_q) begin
			st_n = iib_pkg::ST_PHASE;
		end else if (is_fetch && !fetch_ok) begin
			st_n = iib_pkg::ST_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			rp_q     <= '0;
			sorted_q <= 1'b0;
			pc_q     <= '0;
			wc_q     <= '0;
			done     <= 1'b0;
		end else begin
			done <= cmd.go;
			if (load_ok) begin
				count_q <= count_q + CW'(1);
			end
			if (is_sort) begin
				sorted_q <= 1'b1;
				rp_q     <= '0;
				pc_q     <= '0;
				wc_q     <= '0;
			end
			if (is_clear) begin
				count_q  <= '0;
				sorted_q <= 1'b0;
				rp_q     <= '0;
				pc_q     <= '0;
				wc_q     <= '0;
			end
			if (fetch_ok) begin
				rp_q <= rp_q + CW'(1);
				pc_q <= pc_n;
				wc_q <= wc_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_sort) begin
			m_q <= count_q;
		end
		if (cmd.pass_end) begin
			m_q <= m_q - CW'(1);
		end
		if (cmd.load_carry) begin
			carry_q <= rdata_q;
			j_q     <= AW'(1);
		end
		if (cmd.scan) begin
			carry_q <= hi_val;
			j_q     <= j_q + AW'(1);
		end
		if (cmd.prime1) begin
			cur_q <= rdata_q;
		end
		if (fetch_ok) begin
			prev_q <= cur_q;
			cur_q  <= rdata_q;
		end
		status        <= st_n;
		out_word      <= fetch_ok ? cur_q[EW-1:40] : '0;
		out_doc       <= fetch_ok ? cur_q[39:16] : '0;
		out_pos       <= fetch_ok ? cur_q[15:0] : '0;
		hit_index     <= fetch_ok ? IW'(rp_q) : '0;
		posting_index <= fetch_ok ? pc_n : '0;
		word_index    <= fetch_ok ? wc_n : '0;
		posting_start <= fetch_ok && p_st;
		posting_end   <= fetch_ok && p_en;
		word_start    <= fetch_ok && w_st;
		word_end      <= fetch_ok && w_en;
		last          <= fetch_ok && is_last;
	end

endmodule

[sv/inverted_index_builder.sv]
// Sort-based inverted index builder.
// Command channel: a beat is taken when start is high and busy is low; kind
// selects load, sort, fetch or clear, with word_id/doc_id/pos used by load.
// Every accepted command gives exactly one result beat, with done high for
// one cycle, in the cycle after acceptance. The receiver cannot stall: the
// result must be taken in that cycle.
// Loads, fetches and clears leave busy low and may come back to back.
// Sort of n entries holds busy high while a bubble sequencer walks the store
// through its single read and single write port: each pass reads, loads the
// carry, scans and writes back, and the prime steps then preload the fetch
// window (only the prime steps when n < 2).
// Fetch results carry hit, posting and word indices (low 10 bits) and the
// start/end/last flags; non-fetch and failed beats carry zeros apart from
// status.
// Reset clears count, read pointer, sorted flag and counters at once; the
// store itself is not cleared and needs no sweep.
module inverted_index_builder #(
	parameter int unsigned DEPTH = iib_pkg::DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                kind,
	input  logic [23:0]               word_id,
	input  logic [23:0]               doc_id,
	input  logic [15:0]               pos,
	output logic                      done,
	output logic [1:0]                status,
	output logic [23:0]               out_word,
	output logic [23:0]               out_doc,
	output logic [15:0]               out_pos,
	output logic [iib_pkg::IDX_W-1:0] hit_index,
	output logic [iib_pkg::IDX_W-1:0] posting_index,
	output logic [iib_pkg::IDX_W-1:0] word_index,
	output logic                      posting_start,
	output logic                      posting_end,
	output logic                      word_start,
	output logic                      word_end,
	output logic                      last
);

	iib_pkg::cmd_t  cmd;
	iib_pkg::stat_t stat;

	iib_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	iib_dp #(.DEPTH(DEPTH)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.kind          (kind),
		.word_id       (word_id),
		.doc_id        (doc_id),
		.pos           (pos),
		.done          (done),
		.status        (status),
		.out_word      (out_word),
		.out_doc       (out_doc),
		.out_pos       (out_pos),
		.hit_index     (hit_index),
		.posting_index (posting_index),
		.word_index    (word_index),
		.posting_start (posting_start),
		.posting_end   (posting_end),
		.word_start    (word_start),
		.word_end      (word_end),
		.last          (last)
	);

endmodule

[sv/iib_checker.sv]
module iib_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  status,
	input logic [23:0] out_word,
	input logic        posting_start,
	input logic        posting_end,
	input logic        word_start,
	input logic        word_end,
	input logic        last
);

	a_beat_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("accepted command gave no result beat");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result beat without a command");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != iib_pkg::ST_OK) |-> (out_word == '0 && !last && !posting_start))
		else $error("failed beat carries data");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(done && last) |-> (posting_end && word_end))
		else $error("final hit does not close its groups");

	a_word_opens_posting: assert property (@(posedge clk) disable iff (!arst_n)
		(done && word_start) |-> posting_start)
		else $error("word group opened without a posting");

endmodule

bind inverted_index_builder iib_checker u_iib_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.status        (status),
	.out_word      (out_word),
	.posting_start (posting_start),
	.posting_end   (posting_end),
	.word_start    (word_start),
	.word_end      (word_end),
	.last          (last)
);

[verif/iib_checker.sv]
`timescale 1ns / 1ps

module iib_scoreboard (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  kind,
	input  logic [23:0] word_id,
	input  logic [23:0] doc_id,
	input  logic [15:0] pos,
	input  logic        done,
	input  logic [1:0]  status,
	input  logic [23:0] out_word,
	input  logic [23:0] out_doc,
	input  logic [15:0] out_pos,
	input  logic [9:0]  hit_index,
	input  logic [9:0]  posting_index,
	input  logic [9:0]  word_index,
	input  logic        posting_start,
	input  logic        posting_end,
	input  logic        word_start,
	input  logic        word_end,
	input  logic        last,
	output int          errors,
	output int          pending
);

	localparam int unsigned CAP = iib_pkg::DEPTH_DEF;

	typedef struct packed {
		logic [1:0]  st;
		logic [23:0] w;
		logic [23:0] d;
		logic [15:0] p;
		logic [9:0]  hit;
		logic [9:0]  post;
		logic [9:0]  wrd;
		logic        ps;
		logic        pe;
		logic        ws;
		logic        we;
		logic        lst;
	} hit_beat_t;

	logic [63:0] entries [CAP];
	int          n_entries;
	int          rd_ptr;
	logic        is_sorted;
	logic [9:0]  post_cnt;
	logic [9:0]  word_cnt;
	hit_beat_t   awaited [$];

	task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
		$display("%0t: %s got %0h want %0h", $realtime, field, got, want);
		errors++;
	endtask

	task automatic predict_beat(input logic [1:0] k, input logic [23:0] w, input logic [23:0] d,
			input logic [15:0] p, output hit_beat_t r);
		logic [63:0] q [$];
		logic [63:0] cur;
		logic [63:0] nb;
		r = '0;
		case (iib_pkg::kind_t'(k))
			iib_pkg::KIND_LOAD: begin
				if (is_sorted) r.st = iib_pkg::ST_PHASE;
				else if (n_entries >= CAP) r.st = iib_pkg::ST_FULL;
				else begin
					entries[n_entries] = {w, d, p};
					n_entries++;
				end
			end
			iib_pkg::KIND_SORT: begin
				for (int i = 0; i < n_entries; i++) q = {q, entries[i]};
				q.sort();
				for (int i = 0; i < n_entries; i++) entries[i] = q[i];
				is_sorted = 1'b1;
				rd_ptr = 0;
				post_cnt = '0;
				word_cnt = '0;
			end
			iib_pkg::KIND_FETCH: begin
				if (!is_sorted) r.st = iib_pkg::ST_PHASE;
				else if (rd_ptr >= n_entries) r.st = iib_pkg::ST_EMPTY;
				else begin
					cur = entries[rd_ptr];
					if (rd_ptr == 0) begin
						r.ps = 1'b1;
						r.ws = 1'b1;
					end else begin
						nb = entries[rd_ptr-1];
						r.ps = nb[63:16] != cur[63:16];
						r.ws = nb[63:40] != cur[63:40];
						if (r.ps) post_cnt++;
						if (r.ws) word_cnt++;
					end
					r.lst = rd_ptr + 1 >= n_entries;
					if (r.lst) begin
						r.pe = 1'b1;
						r.we = 1'b1;
					end else begin
						nb = entries[rd_ptr+1];
						r.pe = nb[63:16] != cur[63:16];
						r.we = nb[63:40] != cur[63:40];
					end
					r.w = cur[63:40];
					r.d = cur[39:16];
					r.p = cur[15:0];
					r.hit = rd_ptr[9:0];
					r.post = post_cnt;
					r.wrd = word_cnt;
					rd_ptr++;
				end
			end
			default: begin
				n_entries = 0;
				rd_ptr = 0;
				is_sorted = 1'b0;
				post_cnt = '0;
				word_cnt = '0;
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		hit_beat_t e;
		if (!arst_n) begin
			n_entries = 0;
			rd_ptr = 0;
			is_sorted = 1'b0;
			post_cnt = '0;
			word_cnt = '0;
			errors = 0;
			pending = 0;
			awaited = {};
		end else begin
			// result beat first: it belongs to an earlier command
			if (done) begin
				if (awaited.size() == 0) begin
					report("done", 32'(done), 32'd0);
				end else begin
					e = awaited.pop_front();
					if (status !== e.st) report("status", 32'(status), 32'(e.st));
					if (out_word !== e.w) report("out_word", 32'(out_word), 32'(e.w));
					if (out_doc !== e.d) report("out_doc", 32'(out_doc), 32'(e.d));
					if (out_pos !== e.p) report("out_pos", 32'(out_pos), 32'(e.p));
					if (hit_index !== e.hit)
						report("hit_index", 32'(hit_index), 32'(e.hit));
					if (posting_index !== e.post)
						report("posting_index", 32'(posting_index), 32'(e.post));
					if (word_index !== e.wrd)
						report("word_index", 32'(word_index), 32'(e.wrd));
					if (posting_start !== e.ps)
						report("posting_start", 32'(posting_start), 32'(e.ps));
					if (posting_end !== e.pe)
						report("posting_end", 32'(posting_end), 32'(e.pe));
					if (word_start !== e.ws)
						report("word_start", 32'(word_start), 32'(e.ws));
					if (word_end !== e.we) report("word_end", 32'(word_end), 32'(e.we));
					if (last !== e.lst) report("last", 32'(last), 32'(e.lst));
				end
			end
			if (start && !busy) begin
				predict_beat(kind, word_id, doc_id, pos, e);
				awaited = {awaited, e};
			end
			pending = awaited.size();
		end
	end

endmodule

[verif/tb_inverted_index_builder.sv]
`timescale 1ns / 1ps

module tb_inverted_index_builder;

	localparam int LIMIT = 3000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  kind = iib_pkg::KIND_LOAD;
	logic [23:0] word_id = '0;
	logic [23:0] doc_id = '0;
	logic [15:0] pos = '0;
	logic        done;
	logic [1:0]  status;
	logic [23:0] out_word;
	logic [23:0] out_doc;
	logic [15:0] out_pos;
	logic [9:0]  hit_index;
	logic [9:0]  posting_index;
	logic [9:0]  word_index;
	logic        posting_start;
	logic        posting_end;
	logic        word_start;
	logic        word_end;
	logic        last;
	int          errors;
	int          pending;
	int          n_sent = 0;
	int          cycles = 0;

	always #6 clk = ~clk;

	inverted_index_builder i_dut (.*);

	iib_scoreboard i_chk (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send(input iib_pkg::kind_t k, input logic [23:0] w, input logic [23:0] d,
			input logic [15:0] p);
		int gap;
		gap = $urandom_range(0, 4);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		word_id <= w;
		doc_id <= d;
		pos <= p;
		do @(posedge clk); while (busy);
		n_sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// one load/sort/fetch run with small word and document pools so groups repeat
	task automatic run_set(input int n);
		logic [23:0] wp [4];
		logic [23:0] dp [4];
		int nf;
		foreach (wp[i]) wp[i] = $urandom_range(0, 1) ? 24'($urandom()) : 24'($urandom_range(0, 7));
		foreach (dp[i]) dp[i] = $urandom_range(0, 1) ? 24'($urandom()) : 24'($urandom_range(0, 7));
		send(iib_pkg::KIND_CLEAR, 24'($urandom()), 24'($urandom()), 16'($urandom()));
		for (int i = 0; i < n; i++)
			send(iib_pkg::KIND_LOAD, wp[$urandom_range(0, 3)], dp[$urandom_range(0, 3)],
				$urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom_range(0, 3)));
		send(iib_pkg::KIND_SORT, 24'($urandom()), 24'($urandom()), 16'($urandom()));
		nf = n + $urandom_range(0, 2);
		for (int i = 0; i < nf; i++) begin
			if ($urandom_range(0, 29) == 0) send(iib_pkg::KIND_SORT, '0, '0, '0);
			else if ($urandom_range(0, 29) == 0)
				send(iib_pkg::KIND_LOAD, 24'($urandom()), 24'($urandom()), 16'($urandom()));
			send(iib_pkg::KIND_FETCH, 24'($urandom()), 24'($urandom()), 16'($urandom()));
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		send(iib_pkg::KIND_FETCH, '0, '0, '0);           // fetch before sort
		send(iib_pkg::KIND_SORT, '0, '0, '0);            // sort of empty store
		send(iib_pkg::KIND_FETCH, '0, '0, '0);           // nothing left
		send(iib_pkg::KIND_CLEAR, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
		send(iib_pkg::KIND_LOAD, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
		send(iib_pkg::KIND_LOAD, 24'h000000, 24'h000000, 16'h0000);
		send(iib_pkg::KIND_LOAD, 24'h000000, 24'h000000, 16'h0000);
		send(iib_pkg::KIND_LOAD, 24'h000000, 24'hFFFFFF, 16'h0001);
		send(iib_pkg::KIND_LOAD, 24'hFFFFFF, 24'h000000, 16'hFFFF);
		send(iib_pkg::KIND_LOAD, 24'h000000, 24'h000000, 16'hFFFF);
		send(iib_pkg::KIND_FETCH, '0, '0, '0);
		send(iib_pkg::KIND_SORT, '0, '0, '0);
		send(iib_pkg::KIND_LOAD, 24'h123456, 24'h654321, 16'h5A5A); // load after sort
		for (int i = 0; i < 4; i++) send(iib_pkg::KIND_FETCH, '0, '0, '0);
		send(iib_pkg::KIND_SORT, '0, '0, '0);            // sorting again restarts fetch
		for (int i = 0; i < 7; i++) send(iib_pkg::KIND_FETCH, '0, '0, '0);
		drain();

		// random
		while (n_sent < 670) begin
			if ($urandom_range(0, 9) == 0)
				send(iib_pkg::kind_t'(2'($urandom_range(0, 3))), 24'($urandom()),
					24'($urandom()), 16'($urandom()));
			else
				run_set($urandom_range(1, 24));
			if ($urandom_range(0, 3) == 0) drain();
		end

		drain();
		repeat (10) @(posedge clk);
		if (errors == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

endmodule
